>>> src/pps_pkg.sv
// shared types and constants for the preemptive priority scheduler
package pps_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int PRIO_BITS_DEF = 8;

    localparam int SLOT_W = 4;
    localparam int TIME_IN_W = 16;
    localparam int PRIO_IN_W = 8;
    localparam int TIME_W = 20;
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_RESET = 5'd16;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_UPDATE,
        ST_TAT,
        ST_EMIT
    } t_state_e;

    typedef struct packed {
        logic load_wr;
        logic tick_init;
        logic skip;
        logic scan_rd;
        logic update;
        logic calc_tat;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic done_ge;
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

>>> src/pps_ctrl.sv
// sequencing state machine for the scheduler
module pps_ctrl
    import pps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_command,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall
);

    t_state_e r_state;
    t_state_e n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_command == CMD_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else if (i_sts.done_ge) begin
                        o_cmd.skip = 1'b1;
                        n_state    = ST_EMIT;
                    end else begin
                        o_cmd.tick_init = 1'b1;
                        n_state         = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_TAT;
            end
            ST_TAT: begin
                o_cmd.calc_tat = 1'b1;
                n_state        = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/pps_dpath.sv
// task table, scan registers, clock, completion count and result register
module pps_dpath
    import pps_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_cfg_valid,
    input  logic [PC_W-1:0]       i_cfg_data,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [TIME_IN_W-1:0]  i_arrival,
    input  logic [TIME_IN_W-1:0]  i_burst,
    input  logic [PRIO_IN_W-1:0]  i_prio,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic                  o_busy_res,
    output logic [SLOT_W-1:0]     o_running_slot,
    output logic                  o_finished,
    output logic [TIME_W-1:0]     o_turnaround,
    output logic [TIME_W-1:0]     o_waiting,
    output logic                  o_all_done
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = IW + 1;
    localparam int RW = 3 * TIME_IN_W + PRIO_BITS;
    // row layout: arrival, burst, priority, remaining
    localparam int REM_LO = 0;
    localparam int PRI_LO = TIME_IN_W;
    localparam int BUR_LO = TIME_IN_W + PRIO_BITS;
    localparam int ARR_LO = 2 * TIME_IN_W + PRIO_BITS;

    logic [RW-1:0]        r_mem [MAX_TASKS];
    logic [RW-1:0]        r_rd_row;
    logic [IW-1:0]        r_rd_addr;
    logic [IW-1:0]        r_cmp_idx;
    logic                 r_cmp_vld;

    logic [PC_W-1:0]      r_pc;
    logic [TIME_W-1:0]    r_time;
    logic [CW-1:0]        r_done;

    logic                 r_found;
    logic [IW-1:0]        r_best_idx;
    logic [PRIO_BITS-1:0] r_best_pri;
    logic [TIME_IN_W-1:0] r_best_arr;
    logic [TIME_IN_W-1:0] r_best_bur;
    logic [TIME_IN_W-1:0] r_best_rem;
    logic                 r_fin;
    logic [TIME_W-1:0]    r_tat;

    logic                 r_out_vld;

    logic [CW-1:0]        w_count;
    logic                 w_out_free;
    logic                 w_we;
    logic [IW-1:0]        w_wa;
    logic [RW-1:0]        w_wd;
    logic [TIME_IN_W-1:0] w_rem_dec;
    logic                 w_fin;
    logic [TIME_IN_W-1:0] w_row_arr;
    logic [PRIO_BITS-1:0] w_row_pri;
    logic [TIME_IN_W-1:0] w_row_rem;
    logic                 w_better;
    logic [TIME_W-1:0]    w_wait;

    // effective task count
    always_comb begin
        if (32'(r_pc) > MAX_TASKS) begin
            w_count = CW'(MAX_TASKS);
        end else begin
            w_count = CW'(r_pc);
        end
    end

    assign w_out_free     = !r_out_vld || !i_out_stall;
    assign o_sts.done_ge  = r_done >= w_count;
    assign o_sts.last     = (CW'(r_rd_addr) + CW'(1)) == w_count;
    assign o_sts.out_free = w_out_free;

    // table write port
    assign w_rem_dec = r_best_rem - TIME_IN_W'(1);
    assign w_fin     = r_found && (w_rem_dec == '0);

    always_comb begin
        if (i_cmd.load_wr) begin
            w_we = 32'(i_slot) < MAX_TASKS;
            w_wa = IW'(i_slot);
            w_wd = {i_arrival, i_burst, PRIO_BITS'(i_prio), i_burst};
        end else begin
            w_we = i_cmd.update && r_found;
            w_wa = r_best_idx;
            w_wd = {r_best_arr, r_best_bur, r_best_pri, w_rem_dec};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_cmd.scan_rd) begin
            r_rd_row <= r_mem[r_rd_addr];
        end
    end

    // scan compare on the registered row
    assign w_row_arr = r_rd_row[ARR_LO +: TIME_IN_W];
    assign w_row_pri = r_rd_row[PRI_LO +: PRIO_BITS];
    assign w_row_rem = r_rd_row[REM_LO +: TIME_IN_W];
    assign w_better  = (TIME_W'(w_row_arr) <= r_time) && (w_row_rem != '0)
                       && (!r_found || (w_row_pri < r_best_pri));

    always_ff @(posedge i_clk) begin
        if (r_cmp_vld && w_better) begin
            r_best_idx <= r_cmp_idx;
            r_best_pri <= w_row_pri;
            r_best_arr <= w_row_arr;
            r_best_bur <= r_rd_row[BUR_LO +: TIME_IN_W];
            r_best_rem <= w_row_rem;
        end
        if (i_cmd.scan_rd) begin
            r_cmp_idx <= r_rd_addr;
        end
        if (i_cmd.calc_tat) begin
            if (r_time >= TIME_W'(r_best_arr)) begin
                r_tat <= r_time - TIME_W'(r_best_arr);
            end else begin
                r_tat <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= PC_RESET;
            r_time    <= '0;
            r_done    <= '0;
            r_rd_addr <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_fin     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_pc <= i_cfg_data;
            end
            r_cmp_vld <= i_cmd.scan_rd;
            if (i_cmd.load_wr) begin
                r_time <= '0;
                r_done <= '0;
            end else if (i_cmd.update) begin
                if (r_time != {TIME_W{1'b1}}) begin
                    r_time <= r_time + TIME_W'(1);
                end
                r_done <= r_done + CW'(w_fin);
                r_fin  <= w_fin;
            end
            if (i_cmd.tick_init) begin
                r_rd_addr <= '0;
                r_found   <= 1'b0;
                r_fin     <= 1'b0;
            end else if (i_cmd.scan_rd) begin
                r_rd_addr <= r_rd_addr + IW'(1);
            end
            if (i_cmd.skip) begin
                r_found <= 1'b0;
                r_fin   <= 1'b0;
            end else if (r_cmp_vld && w_better) begin
                r_found <= 1'b1;
            end
        end
    end

    // result word
    always_comb begin
        if (r_tat >= TIME_W'(r_best_bur)) begin
            w_wait = r_tat - TIME_W'(r_best_bur);
        end else begin
            w_wait = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_busy_res     <= r_found;
            o_running_slot <= r_found ? SLOT_W'(r_best_idx) : '0;
            o_finished     <= r_fin;
            o_turnaround   <= r_fin ? r_tat : '0;
            o_waiting      <= r_fin ? w_wait : '0;
            o_all_done     <= r_done >= w_count;
        end
    end

    assign o_out_valid = r_out_vld;

    a_fin_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> r_found)
        else $error("completion flagged without a served task");

    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> w_out_free)
        else $error("result word written over one not yet taken");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_rd |-> (CW'(r_rd_addr) < w_count))
        else $error("scan address beyond task count");

    a_done_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done <= CW'(MAX_TASKS))
        else $error("completion count beyond table depth");

endmodule

>>> src/preemptive_priority_scheduler_top.sv
// top level of the preemptive priority scheduler
//
//  channel   direction  handshake               word
//  in        input      i_in_valid/o_in_stall   command, slot, arrival, burst, prio
//  out       output     o_out_valid/i_out_stall busy_res .. all_done
//  cfg       input      i_cfg_valid/o_cfg_ready process_count
//
// a load writes one row while idle; a tick scans n rows (process_count capped at MAX_TASKS)
// the scan reads one table row per cycle, then flush, update, turnaround and emit follow
// a tick after all tasks are done skips the scan and goes straight to emit
// reset clears clock, done count, out valid and state; table rows are undefined until loaded
// a new word is accepted while a result still waits under i_out_stall; the next result waits
module preemptive_priority_scheduler_top
    import pps_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [TIME_IN_W-1:0] i_arrival,
    input  logic [TIME_IN_W-1:0] i_burst,
    input  logic [PRIO_IN_W-1:0] i_prio,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_busy_res,
    output logic [SLOT_W-1:0]    o_running_slot,
    output logic                 o_finished,
    output logic [TIME_W-1:0]    o_turnaround,
    output logic [TIME_W-1:0]    o_waiting,
    output logic                 o_all_done,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [PC_W-1:0]      i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    pps_dpath #(
        .MAX_TASKS (MAX_TASKS),
        .PRIO_BITS (PRIO_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_slot         (i_slot),
        .i_arrival      (i_arrival),
        .i_burst        (i_burst),
        .i_prio         (i_prio),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_busy_res     (o_busy_res),
        .o_running_slot (o_running_slot),
        .o_finished     (o_finished),
        .o_turnaround   (o_turnaround),
        .o_waiting      (o_waiting),
        .o_all_done     (o_all_done)
    );

endmodule
